[src/kway_heap_merge_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the k-way heap merge unit
// Shared shorthand for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef KWAY_HEAP_MERGE_UNIT_ASSERT_SVH
`define KWAY_HEAP_MERGE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KWHM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KWHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/kwhm_pkg.sv]
// ----------------------------------------------------------------------------
// kwhm_pkg
// Field widths, controller/datapath command and status types, heap order.
// ----------------------------------------------------------------------------
`default_nettype none

package kwhm_pkg;

   localparam int VALUE_W    = 32;
   localparam int WAY_OUT_W  = 4;
   localparam int WAYS_CFG_W = 5;
   localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 5'd10;

   // Commands from the controller, at most one high per cycle.
   typedef struct packed {
      logic load_wr;
      logic merge_start;
      logic pick;
      logic take;
      logic fetch;
      logic cmp;
      logic settle;
      logic emit;
   } cmd_type;

   // Status back from the datapath.
   typedef struct packed {
      logic load_last;
      logic merge_phase;
      logic has_child;
      logic descend;
      logic more_build;
      logic out_free;
   } status_type;

   // Strict heap order: an exhausted entry sits above every value, and two
   // exhausted entries are equal.
   function automatic logic below(input logic signed [VALUE_W-1:0] a_val,
                                  input logic a_exh,
                                  input logic signed [VALUE_W-1:0] b_val,
                                  input logic b_exh);
      return !a_exh && (b_exh || (a_val < b_val));
   endfunction

endpackage

`default_nettype wire

[src/kwhm_if.sv]
// ----------------------------------------------------------------------------
// kwhm channel interfaces
// Valid/ready channels for input words, result words and the way count.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwhm_req_if;
   import kwhm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      way_empty;
   modport source (output valid, value, way_empty, input ready);
   modport sink   (input valid, value, way_empty, output ready);
endinterface

interface kwhm_rsp_if;
   import kwhm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] min_value;
   logic [WAY_OUT_W-1:0]      source_way;
   logic                      done_res;
   modport source (output valid, min_value, source_way, done_res, input ready);
   modport sink   (input valid, min_value, source_way, done_res, output ready);
endinterface

interface kwhm_csr_if;
   import kwhm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WAYS_CFG_W-1:0] ways_in_use;
   modport source (output valid, ways_in_use, input ready);
   modport sink   (input valid, ways_in_use, output ready);
endinterface

`default_nettype wire

[src/kwhm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwhm_ctrl
// Sequencer for load, heap build, sift-down and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kway_heap_merge_unit_assert.svh"

module kwhm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                abort,
   input  wire kwhm_pkg::status_type status,
   output kwhm_pkg::cmd_type        cmd
);
   import kwhm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PICK  = 3'd1;
   localparam logic [2:0] S_TAKE  = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [2:0] sift_exit;

   // Where a finished sift goes: the next build node, or the result.
   assign sift_exit = status.more_build ? S_PICK : S_EMIT;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (status.merge_phase) begin
                  cmd.merge_start = 1'b1;
                  state_in        = S_FETCH;
               end else begin
                  cmd.load_wr = 1'b1;
                  if (status.load_last) begin
                     state_in = S_PICK;
                  end
               end
            end
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (status.has_child) begin
               cmd.fetch = 1'b1;
               state_in  = S_CMP;
            end else begin
               cmd.settle = 1'b1;
               state_in   = sift_exit;
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = status.descend ? S_FETCH : sift_exit;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || abort) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `KWHM_ASSERT_NEXT(a_emit_waits, clock, reset, (state_ff == S_EMIT) && !status.out_free && !abort, state_ff == S_EMIT, "result dropped while output register busy")
   `KWHM_ASSERT_NEXT(a_merge_sifts, clock, reset, (state_ff == S_IDLE) && req_valid && status.merge_phase && !abort, state_ff == S_FETCH, "merge word did not start a sift")
   `KWHM_ASSERT_NEXT(a_load_stays, clock, reset, (state_ff == S_IDLE) && req_valid && !status.merge_phase && !status.load_last && !abort, state_ff == S_IDLE, "early load word left idle")

endmodule

`default_nettype wire

[src/kwhm_datapath.sv]
// ----------------------------------------------------------------------------
// kwhm_datapath
// Heap store, sift registers, counters, way count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kway_heap_merge_unit_assert.svh"

module kwhm_datapath #(
   parameter int MAX_WAYS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire kwhm_pkg::cmd_type                     cmd,
   output kwhm_pkg::status_type                       status,
   input  wire logic signed [kwhm_pkg::VALUE_W-1:0]   req_value,
   input  wire logic                                  req_way_empty,
   input  wire logic                                  csr_fire,
   input  wire logic [kwhm_pkg::WAYS_CFG_W-1:0]       csr_ways_in_use,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic signed [kwhm_pkg::VALUE_W-1:0]        rsp_min_value,
   output logic [kwhm_pkg::WAY_OUT_W-1:0]             rsp_source_way,
   output logic                                       rsp_done_res
);
   import kwhm_pkg::*;

   localparam int AW = $clog2(MAX_WAYS);
   localparam int NW = $clog2(MAX_WAYS + 1);
   localparam int CW = AW + 2;
   localparam int WW = (NW > WAYS_CFG_W) ? NW : WAYS_CFG_W;

   // Heap store; entry 0 (the root) lives in registers instead.
   logic signed [VALUE_W-1:0] mem_val [MAX_WAYS];
   logic [AW-1:0]             mem_way [MAX_WAYS];
   logic                      mem_exh [MAX_WAYS];

   logic [WAYS_CFG_W-1:0] ways_ff;
   logic [NW-1:0]         load_cnt_ff;
   logic [NW-1:0]         exh_cnt_ff;
   logic                  merge_ff;
   logic                  build_ff;
   logic [AW-1:0]         node_ff;
   logic [AW-1:0]         pos_ff;
   logic                  rsp_valid_ff;

   logic signed [VALUE_W-1:0] root_val_ff, cur_val_ff, rda_val_ff, rdb_val_ff;
   logic [AW-1:0]             root_way_ff, cur_way_ff, rda_way_ff, rdb_way_ff;
   logic                      root_exh_ff, cur_exh_ff, rda_exh_ff, rdb_exh_ff;
   logic signed [VALUE_W-1:0] out_val_ff;
   logic [WAY_OUT_W-1:0]      out_way_ff;
   logic                      out_done_ff;

   logic [NW-1:0]             n_eff;
   logic [NW-1:0]             load_pos;
   logic [NW-1:0]             load_next;
   logic [CW-1:0]             lchild;
   logic [CW-1:0]             rchild;
   logic                      has_child;
   logic                      r_ok;
   logic [AW-1:0]             rd_a_idx;
   logic [AW-1:0]             rd_b_idx;
   logic                      take_r;
   logic signed [VALUE_W-1:0] c_val;
   logic [AW-1:0]             c_way;
   logic                      c_exh;
   logic [AW-1:0]             c_idx;
   logic                      descend;
   logic                      sift_end;
   logic                      done_now;
   logic [31:0]               root_way_wide;

   logic                      wr_en;
   logic [AW-1:0]             wr_idx;
   logic signed [VALUE_W-1:0] wr_val;
   logic [AW-1:0]             wr_way;
   logic                      wr_exh;

   // Way count in force: zero acts as one, larger than the store acts as full.
   always_comb begin
      if (ways_ff == '0) begin
         n_eff = NW'(1);
      end else if (WW'(ways_ff) > WW'(MAX_WAYS)) begin
         n_eff = NW'(MAX_WAYS);
      end else begin
         n_eff = NW'(ways_ff);
      end
   end

   assign load_pos  = (load_cnt_ff >= n_eff) ? (n_eff - NW'(1)) : load_cnt_ff;
   assign load_next = load_pos + NW'(1);

   assign lchild    = (CW'(pos_ff) << 1) + CW'(1);
   assign rchild    = lchild + CW'(1);
   assign has_child = (lchild < CW'(n_eff));
   assign r_ok      = (rchild < CW'(n_eff));

   assign rd_a_idx = cmd.pick ? node_ff :
                     ((cmd.fetch && has_child) ? lchild[AW-1:0] : '0);
   assign rd_b_idx = r_ok ? rchild[AW-1:0] : '0;

   // Smaller child, left on ties, then whether it moves above the sifted entry.
   assign take_r  = r_ok && below(rdb_val_ff, rdb_exh_ff, rda_val_ff, rda_exh_ff);
   assign c_val   = take_r ? rdb_val_ff : rda_val_ff;
   assign c_way   = take_r ? rdb_way_ff : rda_way_ff;
   assign c_exh   = take_r ? rdb_exh_ff : rda_exh_ff;
   assign c_idx   = take_r ? rchild[AW-1:0] : lchild[AW-1:0];
   assign descend = below(c_val, c_exh, cur_val_ff, cur_exh_ff);

   assign sift_end = cmd.settle || (cmd.cmp && !descend);
   assign done_now = (exh_cnt_ff >= n_eff);

   always_comb begin
      wr_en  = 1'b0;
      wr_idx = pos_ff;
      wr_val = cur_val_ff;
      wr_way = cur_way_ff;
      wr_exh = cur_exh_ff;
      if (cmd.load_wr) begin
         wr_en  = 1'b1;
         wr_idx = load_pos[AW-1:0];
         wr_val = req_way_empty ? '0 : req_value;
         wr_way = load_pos[AW-1:0];
         wr_exh = req_way_empty;
      end else if (sift_end) begin
         wr_en = 1'b1;
      end else if (cmd.cmp) begin
         wr_en  = 1'b1;
         wr_val = c_val;
         wr_way = c_way;
         wr_exh = c_exh;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx != '0)) begin
         mem_val[wr_idx] <= wr_val;
         mem_way[wr_idx] <= wr_way;
         mem_exh[wr_idx] <= wr_exh;
      end
      rda_val_ff <= mem_val[rd_a_idx];
      rda_way_ff <= mem_way[rd_a_idx];
      rda_exh_ff <= mem_exh[rd_a_idx];
      rdb_val_ff <= mem_val[rd_b_idx];
      rdb_way_ff <= mem_way[rd_b_idx];
      rdb_exh_ff <= mem_exh[rd_b_idx];
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == '0)) begin
         root_val_ff <= wr_val;
         root_way_ff <= wr_way;
         root_exh_ff <= wr_exh;
      end
      if (cmd.merge_start) begin
         cur_val_ff <= req_way_empty ? '0 : req_value;
         cur_way_ff <= root_way_ff;
         cur_exh_ff <= req_way_empty;
      end else if (cmd.take) begin
         cur_val_ff <= (node_ff == '0) ? root_val_ff : rda_val_ff;
         cur_way_ff <= (node_ff == '0) ? root_way_ff : rda_way_ff;
         cur_exh_ff <= (node_ff == '0) ? root_exh_ff : rda_exh_ff;
      end
      if (cmd.emit) begin
         out_val_ff  <= done_now ? '0 : root_val_ff;
         out_way_ff  <= done_now ? '0 : root_way_wide[WAY_OUT_W-1:0];
         out_done_ff <= done_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff      <= WAYS_RESET;
         load_cnt_ff  <= '0;
         exh_cnt_ff   <= '0;
         merge_ff     <= 1'b0;
         build_ff     <= 1'b0;
         node_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // A way-count write takes precedence over any command of the cycle.
         if (csr_fire) begin
            ways_ff     <= csr_ways_in_use;
            load_cnt_ff <= '0;
            exh_cnt_ff  <= '0;
            merge_ff    <= 1'b0;
            build_ff    <= 1'b0;
         end else begin
            if (cmd.load_wr) begin
               load_cnt_ff <= load_next;
               if (req_way_empty) begin
                  exh_cnt_ff <= exh_cnt_ff + NW'(1);
               end
               if (load_next == n_eff) begin
                  merge_ff <= 1'b1;
                  build_ff <= 1'b1;
                  node_ff  <= AW'((n_eff - NW'(1)) >> 1);
               end
            end
            if (cmd.merge_start) begin
               pos_ff <= '0;
               if (req_way_empty) begin
                  if (!root_exh_ff) begin
                     exh_cnt_ff <= exh_cnt_ff + NW'(1);
                  end
               end else if (root_exh_ff && (exh_cnt_ff != '0)) begin
                  exh_cnt_ff <= exh_cnt_ff - NW'(1);
               end
            end
            if (cmd.take) begin
               pos_ff <= node_ff;
            end
            if (cmd.cmp && descend) begin
               pos_ff <= c_idx;
            end
            if (sift_end) begin
               if (build_ff && (node_ff != '0)) begin
                  node_ff <= node_ff - AW'(1);
               end else begin
                  build_ff <= 1'b0;
               end
            end
            if (cmd.emit && done_now) begin
               load_cnt_ff <= '0;
               exh_cnt_ff  <= '0;
               merge_ff    <= 1'b0;
            end
         end
      end
   end

   assign root_way_wide = 32'(root_way_ff);

   assign status.load_last   = (load_next == n_eff);
   assign status.merge_phase = merge_ff;
   assign status.has_child   = has_child;
   assign status.descend     = descend;
   assign status.more_build  = build_ff && (node_ff != '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_value  = out_val_ff;
   assign rsp_source_way = out_way_ff;
   assign rsp_done_res   = out_done_ff;

   `KWHM_ASSERT_IMPLIES(a_exh_bound, clock, reset, 1'b1, exh_cnt_ff <= n_eff,
      "exhausted count above way count")
   `KWHM_ASSERT_IMPLIES(a_wr_in_heap, clock, reset, wr_en, NW'(wr_idx) < n_eff,
      "heap write outside ways in use")

endmodule

`default_nettype wire

[src/kway_heap_merge_unit.sv]
// ----------------------------------------------------------------------------
// kway_heap_merge_unit
// Merges up to MAX_WAYS ascending runs into one ascending stream by a min-heap.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        word contents
//   req_ch   in   valid / ready    value, way_empty
//   rsp_ch   out  valid / ready    min_value, source_way, done_res
//   csr_ch   in   valid / ready    ways_in_use (always ready)
//
// A load word is written into the heap as it is accepted. The last load
// word starts a bottom-up build: each node is read (pick, take), sinks one
// level per read of both children and compare with write-back, and stops
// with a settle write at a leaf or at a compare that keeps it above its
// children; then the minimum moves to the output register. A merge word is
// accepted in place of the root, sifted down in the same steps per heap level,
// settled at a leaf if it gets there, and emitted. The heap memory's single
// write port and two registered read ports set the pace of these steps.
// Reset is synchronous and active high; it sets ways_in_use to ten and
// returns to the load phase. A full output register stalls the block in its
// emit step only; a word is accepted again once the result has moved out.
// The heap store needs no clearing pass, since every entry in use is written
// during the load phase before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_heap_merge_unit #(
   parameter int MAX_WAYS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   kwhm_req_if.sink  req_ch,
   kwhm_rsp_if.source rsp_ch,
   kwhm_csr_if.sink  csr_ch
);
   import kwhm_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_fire;

   // A way-count write is always taken and also abandons any merge.
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   // The sequencer decides what happens each cycle; the datapath holds the
   // heap, the entry being sifted and the counters.
   kwhm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .abort     (csr_fire),
      .status    (status),
      .cmd       (cmd)
   );

   kwhm_datapath #(
      .MAX_WAYS (MAX_WAYS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_ch.value),
      .req_way_empty   (req_ch.way_empty),
      .csr_fire        (csr_fire),
      .csr_ways_in_use (csr_ch.ways_in_use),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_min_value   (rsp_ch.min_value),
      .rsp_source_way  (rsp_ch.source_way),
      .rsp_done_res    (rsp_ch.done_res)
   );

endmodule

`default_nettype wire

[tb/sv/kway_heap_merge_unit_tb.sv]
// ----------------------------------------------------------------------------
// kway_heap_merge_unit_tb
// Self-checking bench for the k-way heap merge unit. A heap model inside a
// small scoreboard class follows every accepted word and way-count write, and
// predicts the minimum, its way and the done flag. Sorted runs are fed back
// through the way the model names, mixed with noise and cut-off merges, while
// both sides of the block stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_heap_merge_unit_tb;
   import kwhm_pkg::*;

   localparam int MAX_WAYS      = 16;
   localparam int WORD_TARGET   = 1500;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Load words are written as they are accepted and only the last gives a result,
   // so this covers any work still in flight once the last result has been taken.
   localparam int SETTLE_CYCLES = 24;
   localparam int TAIL_CYCLES   = 40;
   localparam int LONG_HOLD     = 300;
   localparam int MAX_PRINTED   = 20;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   localparam logic [WAYS_CFG_W-1:0] WAYS_ZERO  = 5'd0;
   localparam logic [WAYS_CFG_W-1:0] WAYS_ONE   = 5'd1;
   localparam logic [WAYS_CFG_W-1:0] WAYS_TWO   = 5'd2;
   localparam logic [WAYS_CFG_W-1:0] WAYS_THREE = 5'd3;
   localparam logic [WAYS_CFG_W-1:0] WAYS_FOUR  = 5'd4;
   localparam logic [WAYS_CFG_W-1:0] WAYS_FULL  = 5'd16;
   localparam logic [WAYS_CFG_W-1:0] WAYS_OVER  = 5'd17;
   localparam logic [WAYS_CFG_W-1:0] WAYS_TOP   = 5'd31;

   // One result word as the block should present it.
   typedef struct {
      logic signed [VALUE_W-1:0] min_value;
      logic [WAY_OUT_W-1:0]      source_way;
      logic                      done_res;
   } heap_result_t;

   // Heap model plus the queue of minima still owed by the block.
   class merge_checker;
      logic [WAYS_CFG_W-1:0]     ways_reg;
      logic signed [VALUE_W-1:0] key [MAX_WAYS];
      int unsigned               owner [MAX_WAYS];
      bit                        spent [MAX_WAYS];
      int unsigned               spent_count;
      int unsigned               heads_loaded;
      bit                        merging;
      heap_result_t              pending_minima [$];
      int                        errors;
      int                        results_seen;
      int                        merges_done;

      function new();
         ways_reg = WAYS_RESET;
         for (int i = 0; i < MAX_WAYS; i++) begin
            key[i]   = '0;
            owner[i] = 0;
            spent[i] = 1'b0;
         end
         errors       = 0;
         results_seen = 0;
         merges_done  = 0;
         restart();
      endfunction

      function void restart();
         heads_loaded = 0;
         spent_count  = 0;
         merging      = 1'b0;
      endfunction

      function int unsigned active_ways();
         if (ways_reg == WAYS_ZERO) return 1;
         if (ways_reg > MAX_WAYS) return MAX_WAYS;
         return ways_reg;
      endfunction

      // Exhausted entries rank above every value and tie with each other.
      function bit lower(int unsigned a, int unsigned b);
         if (spent[a]) return 1'b0;
         if (spent[b]) return 1'b1;
         return key[a] < key[b];
      endfunction

      function void sink_from(int unsigned pos, int unsigned size);
         int unsigned               lc, rc, pick;
         logic signed [VALUE_W-1:0] tk;
         int unsigned               tw;
         bit                        ts;
         forever begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            pick = pos;
            if (lc < size && lower(lc, pick)) pick = lc;
            if (rc < size && lower(rc, pick)) pick = rc;
            if (pick == pos) return;
            tk = key[pos];   key[pos] = key[pick];     key[pick] = tk;
            tw = owner[pos]; owner[pos] = owner[pick]; owner[pick] = tw;
            ts = spent[pos]; spent[pos] = spent[pick]; spent[pick] = ts;
            pos = pick;
         end
      endfunction

      function void publish(int unsigned n);
         heap_result_t r;
         if (spent_count >= n) begin
            r.min_value  = '0;
            r.source_way = '0;
            r.done_res   = 1'b1;
            restart();
         end else begin
            r.min_value  = key[0];
            r.source_way = owner[0][WAY_OUT_W-1:0];
            r.done_res   = 1'b0;
         end
         pending_minima.push_back(r);
      endfunction

      // A write to the way count also throws away any merge in progress.
      function void note_ways(logic [WAYS_CFG_W-1:0] v);
         ways_reg = v;
         restart();
      endfunction

      function void absorb_word(logic signed [VALUE_W-1:0] v, logic empty);
         int unsigned n, p;
         n = active_ways();
         if (!merging) begin
            p = heads_loaded;
            if (p >= n) p = n - 1;
            key[p]   = empty ? '0 : v;
            owner[p] = p;
            spent[p] = empty;
            if (empty) spent_count++;
            heads_loaded = p + 1;
            if (heads_loaded < n) return;
            for (int unsigned i = (n - 1) / 2 + 1; i > 0; i--) sink_from(i - 1, n);
            merging = 1'b1;
            publish(n);
            return;
         end
         if (empty) begin
            if (!spent[0]) spent_count++;
            spent[0] = 1'b1;
            key[0]   = '0;
         end else begin
            if (spent[0] && spent_count > 0) spent_count--;
            spent[0] = 1'b0;
            key[0]   = v;
         end
         sink_from(0, n);
         publish(n);
      endfunction

      function bit in_merge();
         return merging;
      endfunction

      function bit at_start();
         return !merging && heads_loaded == 0;
      endfunction

      function int unsigned root_way();
         return owner[0];
      endfunction

      function int pending();
         return pending_minima.size();
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("MISMATCH at result %0d: %s", results_seen, msg);
      endtask

      task check_result(input logic signed [VALUE_W-1:0] got_value,
                        input logic [WAY_OUT_W-1:0] got_way, input logic got_done);
         heap_result_t want;
         results_seen++;
         if (pending_minima.size() == 0) begin
            report_mismatch($sformatf("unexpected word: value %0d way %0d done %0b",
                                      got_value, got_way, got_done));
         end else begin
            want = pending_minima.pop_front();
            if (got_done !== want.done_res)
               report_mismatch($sformatf("done_res %0b, expected %0b", got_done,
                                         want.done_res));
            if (got_value !== want.min_value)
               report_mismatch($sformatf("min_value %0d, expected %0d", got_value,
                                         want.min_value));
            if (got_way !== want.source_way)
               report_mismatch($sformatf("source_way %0d, expected %0d", got_way,
                                         want.source_way));
            if (want.done_res) merges_done++;
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, channels and the block itself.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   kwhm_req_if req_ch ();
   kwhm_rsp_if rsp_ch ();
   kwhm_csr_if csr_ch ();

   kway_heap_merge_unit #(
      .MAX_WAYS (MAX_WAYS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   merge_checker merge_chk;

   // Shared stimulus state. idling switches the random gaps on both sides;
   // hold_rsp asks the result side for one long stall.
   bit idling   = 1'b0;
   bit hold_rsp = 1'b0;
   int words_sent  = 0;
   int ways_writes = 0;
   int sessions    = 0;
   int cycle_count = 0;

   // Per-way sorted runs for well-formed merges.
   int                        run_len  [MAX_WAYS];
   int                        run_pos  [MAX_WAYS];
   logic signed [VALUE_W-1:0] run_head [MAX_WAYS];
   logic signed [VALUE_W-1:0] run_last [MAX_WAYS];

   // The whole run is bounded; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, merge_chk.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Every handshake is observed at the rising edge. The result is checked
   // before the input word of the same edge is folded in, since a word never
   // produces its result in the cycle it is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            merge_chk.check_result(rsp_ch.min_value, rsp_ch.source_way, rsp_ch.done_res);
         if (csr_ch.valid && csr_ch.ready)
            merge_chk.note_ways(csr_ch.ways_in_use);
         if (req_ch.valid && req_ch.ready)
            merge_chk.absorb_word(req_ch.value, req_ch.way_empty);
      end
   end

   // Result side: random stall bursts while idling is on,
   // and one long hold-off on request so the output register backs up into
   // the input channel.
   initial begin : result_sink
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 10);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers. Each task is entered at a falling edge and returns at one.
   // ------------------------------------------------------------------------

   // Offers one word, possibly after an idle burst, and waits for acceptance.
   task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic empty);
      int gap;
      if (idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.value     <= v;
      req_ch.way_empty <= empty;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Stops offering words and waits until every owed result has been taken.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (merge_chk.pending() != 0);
   endtask

   // The way count is only changed with the block idle. Any merge still open
   // in the model is abandoned by the write, just as in the block.
   task automatic write_ways(input logic [WAYS_CFG_W-1:0] v);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.ways_in_use <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      ways_writes++;
   endtask

   // Mostly small way counts, with the corners mixed in.
   function automatic logic [WAYS_CFG_W-1:0] pick_ways();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0:       return WAYS_ZERO;
            1:       return WAYS_ONE;
            2:       return WAYS_FULL;
            3:       return WAYS_OVER;
            default: return WAYS_TOP;
         endcase
      end
      if (r <= 2) return WAYS_CFG_W'($urandom_range(0, 31));
      return WAYS_CFG_W'($urandom_range(1, 8));
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return VAL_MIN;
         1:       return VAL_MAX - $urandom_range(0, 4);
         2:       return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // Sends the next element of way w's run, or the end-of-run marker once
   // the run is used up. Runs never decrease; steps clamp at the top value.
   task automatic next_in_run(input int w);
      longint nxt;
      longint step;
      if (run_pos[w] >= run_len[w]) begin
         send_word($urandom, 1'b1);
      end else begin
         if (run_pos[w] == 0) begin
            nxt = run_head[w];
         end else begin
            case ($urandom_range(0, 9))
               0:       step = $urandom_range(0, 32'hFFFF_FFFF);
               1, 2, 3: step = $urandom_range(0, 1 << 16);
               default: step = $urandom_range(0, 3);
            endcase
            nxt = longint'(run_last[w]) + step;
            if (nxt > longint'(VAL_MAX)) nxt = VAL_MAX;
         end
         run_last[w] = nxt[VALUE_W-1:0];
         run_pos[w]++;
         send_word(run_last[w], 1'b0);
      end
   endtask

   // A well-formed merge: heads in way order, then each refill goes to the
   // way the model says was just emitted. cap cuts the merge short.
   task automatic run_merge(input int cap);
      int n, r, sent;
      n    = merge_chk.active_ways();
      sent = 0;
      for (int w = 0; w < n; w++) begin
         r = $urandom_range(0, 19);
         if (r < 2) run_len[w] = 0;
         else if (r == 2) run_len[w] = $urandom_range(8, 20);
         else run_len[w] = $urandom_range(1, 5);
         run_pos[w]  = 0;
         run_head[w] = pick_value();
      end
      for (int w = 0; w < n && sent < cap; w++) begin
         next_in_run(w);
         sent++;
      end
      while (merge_chk.in_merge() && sent < cap) begin
         next_in_run(merge_chk.root_way());
         sent++;
      end
   endtask

   // Unordered values and random end markers, until the merge closes or the
   // cap is reached.
   task automatic run_noise(input int cap);
      int sent;
      sent = 0;
      do begin
         send_word(($urandom_range(0, 3) == 0) ? pick_value() : $urandom,
                   $urandom_range(0, 3) == 0);
         sent++;
      end while (!merge_chk.at_start() && sent < cap);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int r;
      merge_chk          = new();
      req_ch.valid       = 1'b0;
      req_ch.value       = '0;
      req_ch.way_empty   = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.ways_in_use = '0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Two ways with the value extremes, each run ending right after its head.
      write_ways(WAYS_TWO);
      send_word(VAL_MAX, 1'b0);
      send_word(VAL_MIN, 1'b0);
      send_word($urandom, 1'b1);
      send_word($urandom, 1'b1);

      // A zero way count acts as one way. An empty head means every way is
      // empty at load, so the done word comes at once.
      write_ways(WAYS_ZERO);
      send_word($urandom, 1'b1);
      send_word(32'sd5, 1'b0);
      send_word(32'sd5, 1'b0);
      send_word($urandom, 1'b1);

      // Equal heads: the left child must win every tie.
      write_ways(WAYS_THREE);
      repeat (4) send_word(32'sd7, 1'b0);
      repeat (3) send_word($urandom, 1'b1);

      // Empty ways at load still sit in the heap as exhausted entries.
      write_ways(WAYS_THREE);
      send_word($urandom, 1'b1);
      send_word(-32'sd5, 1'b0);
      send_word($urandom, 1'b1);
      send_word($urandom, 1'b1);

      // A merge abandoned in its merge phase, then one in its load phase;
      // the second write also goes above the largest way count.
      write_ways(WAYS_TWO);
      send_word(32'sd1, 1'b0);
      send_word(32'sd2, 1'b0);
      send_word(32'sd3, 1'b0);
      write_ways(WAYS_FOUR);
      send_word(32'sd9, 1'b0);
      write_ways(WAYS_OVER);

      // Random merges. The last stretch runs with no idling on either side.
      while (words_sent < WORD_TARGET) begin
         idling = (words_sent < WORD_TARGET * 85 / 100) && ($urandom_range(0, 4) != 0);
         if (sessions == 4 || sessions == 40) begin
            write_ways(sessions == 4 ? WAYS_FULL : WAYS_TOP);
            hold_rsp = 1'b1;
            run_merge(1 << 30);
         end else begin
            if (!merge_chk.at_start() || $urandom_range(0, 2) == 0) write_ways(pick_ways());
            r = $urandom_range(0, 9);
            if (r == 0) run_noise($urandom_range(5, 60));
            else if (r == 1) run_merge($urandom_range(1, 30));
            else run_merge(1 << 30);
         end
         sessions++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (merge_chk.pending() != 0)
         merge_chk.report_mismatch($sformatf("%0d results never arrived",
                                             merge_chk.pending()));

      $display("Run summary: %0d input words over %0d merges, %0d way-count writes.",
               words_sent, sessions, ways_writes);
      $display("Run summary: %0d results checked, %0d done words, %0d mismatches.",
               merge_chk.results_seen, merge_chk.merges_done, merge_chk.errors);
      if (merge_chk.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/kwhm_pkg.sv
src/kwhm_if.sv
src/kwhm_ctrl.sv
src/kwhm_datapath.sv
src/kway_heap_merge_unit.sv
tb/sv/kway_heap_merge_unit_tb.sv
